// File: sv/wfs_pkg.sv
// Package for the waveform statistics block: shared widths and the
// one-hot state type of the arithmetic sequencer. No dependencies.
package wfs_pkg;

	// Width of the wrapping arithmetic used for products, quotients and roots
	localparam int ARITH_W = 64;
	// Width of the reported first-occurrence positions
	localparam int POS_W = 16;

	// Sequencer states of the back end
	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_MEAN   = 10'b00_0000_0010,
		S_RMSDIV = 10'b00_0000_0100,
		S_RMSSQ  = 10'b00_0000_1000,
		S_NN     = 10'b00_0001_0000,
		S_NS     = 10'b00_0010_0000,
		S_MM     = 10'b00_0100_0000,
		S_ACDIV  = 10'b00_1000_0000,
		S_ACSQ   = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} back_state_t;

endpackage

// File: sv/wfs_channels.sv
// Handshake channels of the waveform statistics block: sample input and
// record result. Depends on wfs_pkg.
interface wfs_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, sample, last_sample, input ready);
	modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface wfs_result_if #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 8
);
	localparam int Q_W = SAMPLE_BITS + FRACTION_BITS;

	logic                              valid;
	logic                              ready;
	logic signed [SAMPLE_BITS-1:0]     min_value;
	logic signed [SAMPLE_BITS-1:0]     max_value;
	logic signed [SAMPLE_BITS:0]       mid_doubled;
	logic        [SAMPLE_BITS-1:0]     span;
	logic signed [Q_W-1:0]             mean_q8;
	logic        [Q_W-1:0]             rms_q8;
	logic        [Q_W-1:0]             ac_rms_q8;
	logic        [wfs_pkg::POS_W-1:0]  min_position;
	logic        [wfs_pkg::POS_W-1:0]  max_position;

	modport source (output valid, min_value, max_value, mid_doubled, span, mean_q8,
		rms_q8, ac_rms_q8, min_position, max_position, input ready);
	modport sink   (input valid, min_value, max_value, mid_doubled, span, mean_q8,
		rms_q8, ac_rms_q8, min_position, max_position, output ready);
endinterface

// File: sv/waveform_statistics.sv
// Top level of the waveform statistics block: front end, record queue and
// arithmetic back end. Depends on wfs_pkg, wfs_channels, wfs_front, wfs_queue, wfs_back.
//
//  channel   dir  payload                                       handshake
//  samples   in   sample, last_sample                           valid/ready
//  results   out  min/max, mid_doubled, span, mean/rms/ac_rms,  valid/ready
//                 min/max positions
//
// Samples are taken one per cycle; the front end stalls only while two
// finished records wait in the queue. Each record then takes three divisions,
// two square roots and three shift-add multiplies in the back end.
// A result stalled on the output holds the back end until the register frees.
// Reset clears the accumulators, queue and sequencer at once.
module waveform_statistics #(
	parameter int SAMPLE_BITS   = 16,
	parameter int MAX_SAMPLES   = 65536,
	parameter int FRACTION_BITS = 8
) (
	input logic          clk,
	input logic          arst_n,
	wfs_sample_if.sink   samples,
	wfs_result_if.source results
);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_BITS + CNT_W;
	localparam int SQ_RAW = 2 * SAMPLE_BITS + CNT_W - 2;
	localparam int SQ_W   = (SQ_RAW > wfs_pkg::ARITH_W) ? wfs_pkg::ARITH_W : SQ_RAW;
	localparam int SNAP_W = 2 * SAMPLE_BITS + 2 * wfs_pkg::POS_W + SUM_W + SQ_W + CNT_W;

	logic              push, full, pop, avail;
	logic [SNAP_W-1:0] push_data, pop_data;

	wfs_front #(
		.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W), .SUM_W(SUM_W), .SQ_W(SQ_W),
		.MAX_SAMPLES(MAX_SAMPLES), .SNAP_W(SNAP_W)
	) u_front (
		.clk, .arst_n, .samples, .push, .push_data, .full
	);

	wfs_queue #(.W(SNAP_W)) u_queue (
		.clk, .arst_n, .push, .push_data, .full, .pop, .avail, .pop_data
	);

	wfs_back #(
		.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS), .CNT_W(CNT_W),
		.SUM_W(SUM_W), .SQ_W(SQ_W), .SNAP_W(SNAP_W)
	) u_back (
		.clk, .arst_n, .avail, .pop_data, .pop, .results
	);

endmodule

// File: sv/wfs_front.sv
// Front end: accepts samples, keeps count, extremes, sum and sum of squares,
// and pushes a record snapshot on the last sample. Depends on wfs_pkg.
module wfs_front #(
	parameter int SAMPLE_BITS = 16,
	parameter int CNT_W       = 17,
	parameter int SUM_W       = 33,
	parameter int SQ_W        = 47,
	parameter int MAX_SAMPLES = 65536,
	parameter int SNAP_W      = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	wfs_sample_if.sink        samples,
	output logic              push,
	output logic [SNAP_W-1:0] push_data,
	input  logic              full
);
	localparam int PW = wfs_pkg::POS_W;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] low;
		logic signed [SAMPLE_BITS-1:0] high;
		logic [PW-1:0]                 low_idx;
		logic [PW-1:0]                 high_idx;
		logic signed [SUM_W-1:0]       sum;
		logic [SQ_W-1:0]               sumsq;
		logic [CNT_W-1:0]              cnt;
	} snap_t;

	logic [CNT_W-1:0]              cnt_q, cnt_n;
	logic signed [SAMPLE_BITS-1:0] low_q, low_n, high_q, high_n;
	logic [PW-1:0]                 lidx_q, lidx_n, hidx_q, hidx_n;
	logic signed [SUM_W-1:0]       sum_q, sum_n;
	logic [SQ_W-1:0]               sumsq_q, sumsq_n;
	logic signed [2*SAMPLE_BITS-1:0] sq;
	logic                          take, room;
	snap_t                         snap;

	assign samples.ready = !full;
	assign take = samples.valid && samples.ready;
	assign room = cnt_q < CNT_W'(MAX_SAMPLES);
	assign sq   = samples.sample * samples.sample;

	// Next accumulator values; samples past the record limit are dropped
	always_comb begin
		cnt_n   = cnt_q;
		low_n   = low_q;
		high_n  = high_q;
		lidx_n  = lidx_q;
		hidx_n  = hidx_q;
		sum_n   = sum_q;
		sumsq_n = sumsq_q;
		if (room) begin
			if (cnt_q == '0 || samples.sample < low_q) begin
				low_n  = samples.sample;
				lidx_n = PW'(cnt_q);
			end
			if (cnt_q == '0 || samples.sample > high_q) begin
				high_n = samples.sample;
				hidx_n = PW'(cnt_q);
			end
			sum_n   = sum_q + SUM_W'(samples.sample);
			sumsq_n = sumsq_q + SQ_W'($unsigned(sq));
			cnt_n   = cnt_q + 1'b1;
		end
	end

	always_comb begin
		snap.low      = low_n;
		snap.high     = high_n;
		snap.low_idx  = lidx_n;
		snap.high_idx = hidx_n;
		snap.sum      = sum_n;
		snap.sumsq    = sumsq_n;
		snap.cnt      = cnt_n;
	end

	assign push      = take && samples.last_sample;
	assign push_data = snap;

	// Accumulators, cleared at the end of each record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			lidx_q  <= '0;
			hidx_q  <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (take) begin
			if (samples.last_sample) begin
				cnt_q   <= '0;
				low_q   <= '0;
				high_q  <= '0;
				lidx_q  <= '0;
				hidx_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end else begin
				cnt_q   <= cnt_n;
				low_q   <= low_n;
				high_q  <= high_n;
				lidx_q  <= lidx_n;
				hidx_q  <= hidx_n;
				sum_q   <= sum_n;
				sumsq_q <= sumsq_n;
			end
		end
	end

endmodule

// File: sv/wfs_queue.sv
// Two-entry record queue between front and back end. No dependencies.
module wfs_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         avail,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   fill_q;

	assign full     = fill_q == 2'd2;
	assign avail    = fill_q != 2'd0;
	assign pop_data = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			if (push && !pop)      fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

endmodule

// File: sv/wfs_back.sv
// Back end: per record, a shared bit-serial divider, multiplier and square
// root work out mean, RMS and AC RMS into a result register. Depends on wfs_pkg.
module wfs_back #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 8,
	parameter int CNT_W         = 17,
	parameter int SUM_W         = 33,
	parameter int SQ_W          = 47,
	parameter int SNAP_W        = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  logic [SNAP_W-1:0] pop_data,
	output logic              pop,
	wfs_result_if.source      results
);
	localparam int AW     = wfs_pkg::ARITH_W;
	localparam int PW     = wfs_pkg::POS_W;
	localparam int Q_W    = SAMPLE_BITS + FRACTION_BITS;
	localparam int DIVN_W = AW + 2 * FRACTION_BITS;
	localparam int STEP_W = $clog2(DIVN_W);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] low;
		logic signed [SAMPLE_BITS-1:0] high;
		logic [PW-1:0]                 low_idx;
		logic [PW-1:0]                 high_idx;
		logic signed [SUM_W-1:0]       sum;
		logic [SQ_W-1:0]               sumsq;
		logic [CNT_W-1:0]              cnt;
	} snap_t;

	wfs_pkg::back_state_t state_q;
	snap_t        snap_q, in_snap;
	logic [AW-1:0] mag_q, mean_q, rms_q, n2_q, nsq_q, in_mag;
	logic          neg_q;
	logic [DIVN_W-1:0] dvd_q, dvd_n;
	logic [AW:0]   rem_q, rem_sh, rem_n;
	logic [AW-1:0] den_q;
	logic [AW-1:0] ma_q, mb_q, prod_q;
	logic [AW-1:0] sx_q, sres_q, sbit_q, sx_n, sres_n;
	logic [AW:0]   strial;
	logic [STEP_W-1:0] step_q;
	logic          div_last, sq_last, mul_done, out_free;
	logic [AW-1:0] quot, ac_diff;

	assign in_snap = snap_t'(pop_data);
	assign in_mag  = in_snap.sum[SUM_W-1] ? AW'(-in_snap.sum) : AW'(in_snap.sum);
	assign pop     = (state_q == wfs_pkg::S_IDLE) && avail;

	// Restoring divider step
	always_comb begin
		rem_sh = {rem_q[AW-1:0], dvd_q[DIVN_W-1]};
		if (rem_sh >= {1'b0, den_q}) begin
			rem_n = rem_sh - {1'b0, den_q};
			dvd_n = {dvd_q[DIVN_W-2:0], 1'b1};
		end else begin
			rem_n = rem_sh;
			dvd_n = {dvd_q[DIVN_W-2:0], 1'b0};
		end
	end
	assign quot     = dvd_n[AW-1:0];
	assign div_last = step_q == STEP_W'(DIVN_W - 1);

	// Digit-by-digit square root step
	always_comb begin
		strial = {1'b0, sres_q} + {1'b0, sbit_q};
		if ({1'b0, sx_q} >= strial) begin
			sx_n   = sx_q - strial[AW-1:0];
			sres_n = (sres_q >> 1) + sbit_q;
		end else begin
			sx_n   = sx_q;
			sres_n = sres_q >> 1;
		end
	end
	assign sq_last = step_q == STEP_W'(AW / 2 - 1);

	assign mul_done = mb_q == '0;
	assign ac_diff  = nsq_q - prod_q;
	assign out_free = !results.valid || results.ready;

	// Sequencer with shared arithmetic units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfs_pkg::S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				wfs_pkg::S_IDLE: begin
					if (avail) begin
						step_q  <= '0;
						state_q <= wfs_pkg::S_MEAN;
					end
				end
				wfs_pkg::S_MEAN, wfs_pkg::S_RMSDIV, wfs_pkg::S_ACDIV: begin
					step_q <= div_last ? '0 : step_q + 1'b1;
					if (div_last) begin
						state_q <= (state_q == wfs_pkg::S_MEAN) ? wfs_pkg::S_RMSDIV
							: (state_q == wfs_pkg::S_RMSDIV) ? wfs_pkg::S_RMSSQ
							: wfs_pkg::S_ACSQ;
					end
				end
				wfs_pkg::S_RMSSQ, wfs_pkg::S_ACSQ: begin
					step_q <= sq_last ? '0 : step_q + 1'b1;
					if (sq_last) begin
						state_q <= (state_q == wfs_pkg::S_RMSSQ) ? wfs_pkg::S_NN
							: wfs_pkg::S_DONE;
					end
				end
				wfs_pkg::S_NN: if (mul_done) state_q <= wfs_pkg::S_NS;
				wfs_pkg::S_NS: if (mul_done) state_q <= wfs_pkg::S_MM;
				wfs_pkg::S_MM: begin
					if (mul_done) begin
						step_q  <= '0;
						state_q <= wfs_pkg::S_ACDIV;
					end
				end
				wfs_pkg::S_DONE: if (out_free) state_q <= wfs_pkg::S_IDLE;
				default: state_q <= wfs_pkg::S_IDLE;
			endcase
		end
	end

	// Operand and intermediate registers
	always_ff @(posedge clk) begin
		case (state_q)
			wfs_pkg::S_IDLE: begin
				snap_q <= in_snap;
				mag_q  <= in_mag;
				neg_q  <= in_snap.sum[SUM_W-1];
				dvd_q  <= DIVN_W'(in_mag) << FRACTION_BITS;
				rem_q  <= '0;
				den_q  <= AW'(in_snap.cnt);
			end
			wfs_pkg::S_MEAN: begin
				dvd_q <= dvd_n;
				rem_q <= rem_n;
				if (div_last) begin
					mean_q <= quot;
					dvd_q  <= DIVN_W'(snap_q.sumsq) << (2 * FRACTION_BITS);
					rem_q  <= '0;
				end
			end
			wfs_pkg::S_RMSDIV, wfs_pkg::S_ACDIV: begin
				dvd_q <= dvd_n;
				rem_q <= rem_n;
				if (div_last) begin
					sx_q   <= quot;
					sres_q <= '0;
					sbit_q <= AW'(1) << (AW - 2);
				end
			end
			wfs_pkg::S_RMSSQ, wfs_pkg::S_ACSQ: begin
				sx_q   <= sx_n;
				sres_q <= sres_n;
				sbit_q <= sbit_q >> 2;
				if (sq_last && state_q == wfs_pkg::S_RMSSQ) begin
					rms_q  <= sres_n;
					ma_q   <= AW'(snap_q.cnt);
					mb_q   <= AW'(snap_q.cnt);
					prod_q <= '0;
				end
			end
			wfs_pkg::S_NN, wfs_pkg::S_NS, wfs_pkg::S_MM: begin
				if (mul_done) begin
					prod_q <= '0;
					if (state_q == wfs_pkg::S_NN) begin
						n2_q <= prod_q;
						ma_q <= AW'(snap_q.cnt);
						mb_q <= AW'(snap_q.sumsq);
					end else if (state_q == wfs_pkg::S_NS) begin
						nsq_q <= prod_q;
						ma_q  <= mag_q;
						mb_q  <= mag_q;
					end else begin
						dvd_q <= DIVN_W'(ac_diff) << (2 * FRACTION_BITS);
						rem_q <= '0;
						den_q <= n2_q;
					end
				end else begin
					if (mb_q[0]) prod_q <= prod_q + ma_q;
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (state_q == wfs_pkg::S_DONE && out_free) begin
			results.valid <= 1'b1;
		end else if (results.ready) begin
			results.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wfs_pkg::S_DONE && out_free) begin
			results.min_value    <= snap_q.low;
			results.max_value    <= snap_q.high;
			results.mid_doubled  <= (SAMPLE_BITS+1)'(snap_q.high) + (SAMPLE_BITS+1)'(snap_q.low);
			results.span         <= SAMPLE_BITS'(snap_q.high - snap_q.low);
			results.mean_q8      <= neg_q ? Q_W'(-mean_q) : Q_W'(mean_q);
			results.rms_q8       <= rms_q[Q_W-1:0];
			results.ac_rms_q8    <= sres_q[Q_W-1:0];
			results.min_position <= snap_q.low_idx;
			results.max_position <= snap_q.high_idx;
		end
	end

endmodule

// File: sv/wfs_checker.sv
// Port-level checks on the result channel of the waveform statistics block,
// bound to the top level. Depends on waveform_statistics.
module wfs_port_checks #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   o_valid,
	input logic                   o_ready,
	input logic [SAMPLE_BITS-1:0] min_v,
	input logic [SAMPLE_BITS-1:0] max_v,
	input logic [SAMPLE_BITS:0]   mid_v,
	input logic [SAMPLE_BITS-1:0] span_v
);
	logic [SAMPLE_BITS:0]   mid_calc;
	logic [SAMPLE_BITS-1:0] span_calc;

	assign mid_calc  = {max_v[SAMPLE_BITS-1], max_v} + {min_v[SAMPLE_BITS-1], min_v};
	assign span_calc = max_v - min_v;

	// No result is offered while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !o_valid)
		else $error("result valid during reset");

	// A stalled transaction keeps its minimum and maximum
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable(min_v) && $stable(max_v))
		else $error("stalled result changed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> $signed(min_v) <= $signed(max_v))
		else $error("minimum above maximum");

	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> mid_v == mid_calc)
		else $error("mid_doubled mismatch");

	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> span_v == span_calc)
		else $error("span mismatch");

endmodule

bind waveform_statistics wfs_port_checks #(.SAMPLE_BITS(SAMPLE_BITS)) u_wfs_port_checks (
	.clk(clk), .arst_n(arst_n), .o_valid(results.valid), .o_ready(results.ready),
	.min_v(results.min_value), .max_v(results.max_value),
	.mid_v(results.mid_doubled), .span_v(results.span)
);
